// ===== rtl/core/column_run_skip_decompressor_top_macros.svh =====
// assertion macros shared by the decompressor rtl
`ifndef COLUMN_RUN_SKIP_DECOMPRESSOR_TOP_MACROS_SVH
`define COLUMN_RUN_SKIP_DECOMPRESSOR_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define CRSD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("crsd assertion failed");

// next-cycle implication, checked outside reset
`define CRSD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("crsd assertion failed");

`endif

// ===== rtl/core/crsd_pkg.sv =====
// shared types and constants of the column run/skip decompressor
package crsd_pkg;

    // operation codes of an input item
    localparam logic OP_RUN  = 1'b0;
    localparam logic OP_DATA = 1'b1;

    // configuration register indexes
    localparam logic CFG_LINE_WORDS   = 1'b0;
    localparam logic CFG_SCREEN_LINES = 1'b1;

    // configuration reset values
    localparam logic [7:0] LINE_WORDS_RESET   = 8'd80;
    localparam logic [7:0] SCREEN_LINES_RESET = 8'd200;

    typedef struct packed {
        logic        operation;
        logic [7:0]  copy_count;
        logic [7:0]  skip_count;
        logic [15:0] pixel_word;
    } t_in_item;

    typedef struct packed {
        logic        write_enable;
        logic [15:0] word_address;
        logic [15:0] word_data;
        logic        format_error;
    } t_out_item;

    typedef struct packed {
        logic [7:0] line_words;
        logic [7:0] screen_lines;
    } t_cfg;

    // result of adding a skip with at most one column wrap
    typedef struct packed {
        logic       ok;
        logic [7:0] line;
        logic [7:0] col;
    } t_skip_res;

endpackage

// ===== rtl/core/crsd_cfg_regs.sv =====
// configuration registers: line width and column height
module crsd_cfg_regs
    import crsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    // writes are always taken
    assign o_cfg_ready = 1'b1;

    // register write on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_words   <= LINE_WORDS_RESET;
            r_cfg.screen_lines <= SCREEN_LINES_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LINE_WORDS:   r_cfg.line_words   <= i_cfg_data;
                CFG_SCREEN_LINES: r_cfg.screen_lines <= i_cfg_data;
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/crsd_in_stage.sv =====
// input register stage with stall back to the source
module crsd_in_stage
    import crsd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_item,
    input  logic     i_take_ok,
    output logic     o_valid,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;

    // hold only while a registered item cannot move on
    assign o_stall = r_valid && !i_take_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    // payload capture on transfer
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== rtl/core/crsd_core.sv =====
// position tracking, format checks and the registered result
`include "column_run_skip_decompressor_top_macros.svh"

module crsd_core
    import crsd_pkg::*;
#(
    parameter int ADDRESS_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_valid,
    input  t_in_item  i_item,
    output logic      o_take_ok,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam logic [15:0] AddrMask =
        (ADDRESS_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << ADDRESS_BITS) - 32'd1);

    logic [7:0] r_line, n_line;
    logic [7:0] r_col, n_col;
    logic [7:0] r_copies, n_copies;
    logic [7:0] r_skip, n_skip;
    logic       r_out_valid;
    t_out_item  r_out_item, n_out_item;

    logic       out_free;
    logic       advance;
    logic       err;
    logic [8:0] down_line;
    logic       down_wrap;
    logic [7:0] adv_line;
    logic [7:0] adv_col;
    logic [15:0] line_base;
    logic [15:0] addr;
    t_skip_res  run_skip;
    t_skip_res  end_skip;

    // column step saturates at the last column
    function automatic logic [7:0] next_col(input logic [7:0] col);
        next_col = (col == 8'hFF) ? 8'hFF : col + 8'd1;
    endfunction

    // add a skip to the line, allowing one wrap into the next column
    function automatic t_skip_res apply_skip(input logic [7:0] line,
                                             input logic [7:0] col,
                                             input logic [7:0] skip,
                                             input logic [7:0] lines);
        logic [8:0] sum;
        logic [8:0] rem;
        t_skip_res  res;
        sum     = {1'b0, line} + {1'b0, skip};
        rem     = sum;
        res.ok  = 1'b1;
        res.col = col;
        if (sum >= {1'b0, lines}) begin
            rem     = sum - {1'b0, lines};
            res.col = next_col(col);
            res.ok  = (rem < {1'b0, lines});
        end
        res.line = rem[7:0];
        return res;
    endfunction

    // handshake between input stage and result register
    assign out_free  = !r_out_valid || !i_out_stall;
    assign advance   = i_valid && out_free;
    assign o_take_ok = out_free;

    // position after one write
    assign down_line = {1'b0, r_line} + 9'd1;
    assign down_wrap = (down_line >= {1'b0, i_cfg.screen_lines});
    assign adv_line  = down_wrap ? 8'd0 : down_line[7:0];
    assign adv_col   = down_wrap ? next_col(r_col) : r_col;

    // skip paths: run with no copies, and end of a run
    assign run_skip = apply_skip(r_line, r_col, i_item.skip_count, i_cfg.screen_lines);
    assign end_skip = apply_skip(adv_line, adv_col, r_skip, i_cfg.screen_lines);

    // screen word address
    assign line_base = {8'd0, r_line} * {8'd0, i_cfg.line_words};
    assign addr      = (line_base + {8'd0, r_col}) & AddrMask;

    // next state and result
    always_comb begin
        n_line     = r_line;
        n_col      = r_col;
        n_copies   = r_copies;
        n_skip     = r_skip;
        n_out_item = '0;
        err        = 1'b0;
        case (i_item.operation)
            OP_RUN: begin
                if (r_copies != 8'd0) begin
                    err = 1'b1;
                end else if (i_item.copy_count == 8'd0) begin
                    if (run_skip.ok) begin
                        n_line = run_skip.line;
                        n_col  = run_skip.col;
                    end else begin
                        err = 1'b1;
                    end
                end else begin
                    n_copies = i_item.copy_count;
                    n_skip   = i_item.skip_count;
                end
            end
            OP_DATA: begin
                if (r_copies == 8'd0 || r_col >= i_cfg.line_words) begin
                    err = 1'b1;
                end else if (r_copies == 8'd1) begin
                    if (end_skip.ok) begin
                        n_line   = end_skip.line;
                        n_col    = end_skip.col;
                        n_copies = 8'd0;
                        n_skip   = 8'd0;
                    end else begin
                        err = 1'b1;
                    end
                end else begin
                    n_line   = adv_line;
                    n_col    = adv_col;
                    n_copies = r_copies - 8'd1;
                end
                if (!err) begin
                    n_out_item.write_enable = 1'b1;
                    n_out_item.word_address = addr;
                    n_out_item.word_data    = i_item.pixel_word;
                end
            end
            default: begin
                err = 1'b1;
            end
        endcase
        n_out_item.format_error = err;
    end

    // position and run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line   <= 8'd0;
            r_col    <= 8'd0;
            r_copies <= 8'd0;
            r_skip   <= 8'd0;
        end else if (advance) begin
            r_line   <= n_line;
            r_col    <= n_col;
            r_copies <= n_copies;
            r_skip   <= n_skip;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= i_valid;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // checks
    `CRSD_ASSERT_IMP(a_no_write_on_error, i_clk, i_rst_n,
        r_out_valid, !(r_out_item.write_enable && r_out_item.format_error))
    `CRSD_ASSERT_IMP(a_skip_idle_without_run, i_clk, i_rst_n,
        r_copies == 8'd0, r_skip == 8'd0)
    `CRSD_ASSERT_NXT(a_write_uses_one_copy, i_clk, i_rst_n,
        advance && i_item.operation == OP_DATA && !err,
        r_copies == $past(r_copies) - 8'd1)
    `CRSD_ASSERT_NXT(a_error_keeps_position, i_clk, i_rst_n,
        advance && err, $stable(r_line) && $stable(r_col) && $stable(r_copies))

endmodule

// ===== rtl/core/column_run_skip_decompressor_top.sv =====
// top level of the column run/skip decompressor
// path: an item passes the input register, then the result register, where its
// result becomes valid; one result per item
// throughput: one item per cycle while the result register is not held by i_out_stall
// reset: clears position and run counters, sets line_words 80, screen_lines 200
module column_run_skip_decompressor_top
    import crsd_pkg::*;
#(
    parameter int ADDRESS_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_item,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    t_cfg     cfg;
    logic     stage_valid;
    t_in_item stage_item;
    logic     take_ok;

    // configuration registers
    crsd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // input register
    crsd_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_item    (i_in_item),
        .i_take_ok (take_ok),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    // decode, position update and result register
    crsd_core #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (stage_valid),
        .i_item      (stage_item),
        .o_take_ok   (take_ok),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== tb/column_run_skip_decompressor_top_tb.sv =====
// self-checking testbench of the column run/skip decompressor top level
module column_run_skip_decompressor_top_tb;
    import crsd_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 80;
    localparam int HOLD_AT_ITEM = 300;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic       index;
        logic [7:0] data;
    } t_reg_write;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in_item;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out_item;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_index;
    logic [7:0] i_cfg_data;

    // items waiting to be offered, writes waiting to be seen, register writes waiting
    t_in_item   pending_items[$];
    t_out_item  expected_writes[$];
    t_reg_write pending_regs[$];

    // predicted position and run counters, and the register copies
    logic [7:0] pos_line;
    logic [7:0] pos_col;
    logic [7:0] copies_left;
    logic [7:0] skip_left;
    logic [7:0] cfg_lw;
    logic [7:0] cfg_sl;

    int  mismatches;
    int  accepted_items;
    int  quiet_cycles;
    int  hold_left;
    bit  hold_done;
    bit  calm;

    column_run_skip_decompressor_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // next column, saturating at the top
    function automatic logic [7:0] col_step(input logic [7:0] col);
        return (col == 8'd255) ? 8'd255 : col + 8'd1;
    endfunction

    // add a skip to a position, allowing one column wrap at most
    function automatic t_skip_res skip_move(input int line, input logic [7:0] col,
                                            input int skip);
        t_skip_res r;
        int        t;
        t = line + skip;
        r.col = col;
        r.ok = 1'b1;
        if (t >= int'(cfg_sl)) begin
            t = t - int'(cfg_sl);
            r.col = col_step(col);
            if (t >= int'(cfg_sl)) r.ok = 1'b0;
        end
        r.line = t[7:0];
        return r;
    endfunction

    // expected result of one item, updating the predicted position
    function automatic t_out_item predict_write(input t_in_item it);
        t_out_item r;
        t_skip_res s;
        int        addr;
        int        nline;
        logic [7:0] ncol;
        r = '0;
        if (it.operation == OP_RUN) begin
            if (copies_left != 8'd0) begin
                r.format_error = 1'b1;
            end else if (it.copy_count == 8'd0) begin
                s = skip_move(int'(pos_line), pos_col, int'(it.skip_count));
                if (s.ok) begin
                    pos_line = s.line;
                    pos_col = s.col;
                end else begin
                    r.format_error = 1'b1;
                end
            end else begin
                copies_left = it.copy_count;
                skip_left = it.skip_count;
            end
            return r;
        end
        if (copies_left == 8'd0 || pos_col >= cfg_lw) begin
            r.format_error = 1'b1;
            return r;
        end
        addr = int'(pos_line) * int'(cfg_lw) + int'(pos_col);
        nline = int'(pos_line) + 1;
        ncol = pos_col;
        if (nline >= int'(cfg_sl)) begin
            nline = 0;
            ncol = col_step(ncol);
        end
        // the last copy of a run also takes the skip
        if (copies_left == 8'd1) begin
            s = skip_move(nline, ncol, int'(skip_left));
            if (!s.ok) begin
                r.format_error = 1'b1;
                return r;
            end
            nline = int'(s.line);
            ncol = s.col;
            skip_left = 8'd0;
        end
        pos_line = nline[7:0];
        pos_col = ncol;
        copies_left = copies_left - 8'd1;
        r.write_enable = 1'b1;
        r.word_address = addr[15:0];
        r.word_data = it.pixel_word;
        return r;
    endfunction

    // item sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_item <= '0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (i_in_valid) void'(pending_items.pop_front());
            if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 14)) begin
                i_in_valid <= 1'b1;
                i_in_item <= pending_items[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // register writer, keeping the register copies in step
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
            i_cfg_index <= CFG_LINE_WORDS;
            i_cfg_data <= 8'd0;
            cfg_lw = LINE_WORDS_RESET;
            cfg_sl = SCREEN_LINES_RESET;
        end else if (!i_cfg_valid || o_cfg_ready) begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_LINE_WORDS:   cfg_lw = i_cfg_data;
                    CFG_SCREEN_LINES: cfg_sl = i_cfg_data;
                    default:          ;
                endcase
                void'(pending_regs.pop_front());
            end
            if (pending_regs.size() != 0) begin
                i_cfg_valid <= 1'b1;
                i_cfg_index <= pending_regs[0].index;
                i_cfg_data <= pending_regs[0].data;
            end else begin
                i_cfg_valid <= 1'b0;
            end
        end
    end

    // result receiver stall, with one long hold-off to fill the block
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && accepted_items >= HOLD_AT_ITEM) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(0, 99) < 14);
        end
    end

    // monitor: check each result transfer, predict each item transfer
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            pos_line = 8'd0;
            pos_col = 8'd0;
            copies_left = 8'd0;
            skip_left = 8'd0;
            accepted_items <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_writes.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: we=%0d addr=%h data=%h err=%0d",
                                 o_out_item.write_enable, o_out_item.word_address,
                                 o_out_item.word_data, o_out_item.format_error);
                end else begin
                    want = expected_writes.pop_front();
                    if (o_out_item.write_enable !== want.write_enable ||
                        o_out_item.word_address !== want.word_address ||
                        o_out_item.word_data !== want.word_data ||
                        o_out_item.format_error !== want.format_error) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= MAX_REPORTS)
                            $display("mismatch: expected we=%0d addr=%h data=%h err=%0d, %s",
                                     want.write_enable, want.word_address, want.word_data,
                                     want.format_error,
                                     $sformatf("got we=%0d addr=%h data=%h err=%0d",
                                               o_out_item.write_enable,
                                               o_out_item.word_address,
                                               o_out_item.word_data,
                                               o_out_item.format_error));
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                expected_writes.push_back(predict_write(i_in_item));
                accepted_items <= accepted_items + 1;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_in_item run_item(input int copy, input int skip);
        t_in_item it;
        it.operation = OP_RUN;
        it.copy_count = copy[7:0];
        it.skip_count = skip[7:0];
        it.pixel_word = 16'($urandom);
        return it;
    endfunction

    function automatic t_in_item data_item(input logic [15:0] pix);
        t_in_item it;
        it.operation = OP_DATA;
        it.copy_count = 8'($urandom);
        it.skip_count = 8'($urandom);
        it.pixel_word = pix;
        return it;
    endfunction

    // wait until every transfer is done and the pipeline has drained
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || i_in_valid || pending_regs.size() != 0 ||
               i_cfg_valid || expected_writes.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_regs(input int lw, input int sl);
        wait_idle();
        pending_regs.push_back({CFG_LINE_WORDS, lw[7:0]});
        pending_regs.push_back({CFG_SCREEN_LINES, sl[7:0]});
        wait_idle();
    endtask

    // mostly well-formed runs with random content, some noise items
    task automatic push_random(input int n, input int sl);
        int made;
        int copy;
        int skip;
        int r;
        t_in_item it;
        made = 0;
        while (made < n) begin
            if ($urandom_range(0, 99) < 85) begin
                r = $urandom_range(0, 99);
                if (r < 15) copy = 0;
                else if (r < 85) copy = $urandom_range(1, 6);
                else if (r < 97) copy = $urandom_range(7, 40);
                else copy = $urandom_range(0, 255);
                r = $urandom_range(0, 99);
                if (r < 70) skip = $urandom_range(0, sl / 8);
                else if (r < 90) skip = $urandom_range(0, (2 * sl > 255) ? 255 : 2 * sl);
                else skip = $urandom_range(0, 255);
                pending_items.push_back(run_item(copy, skip));
                made = made + 1;
                repeat (copy) begin
                    pending_items.push_back(data_item(16'($urandom)));
                    made = made + 1;
                end
            end else begin
                it.operation = 1'($urandom_range(0, 1));
                it.copy_count = 8'($urandom);
                it.skip_count = 8'($urandom);
                it.pixel_word = 16'($urandom);
                pending_items.push_back(it);
                made = made + 1;
            end
        end
    endtask

    initial begin
        int lw;
        int sl;
        i_rst_n = 1'b0;
        calm = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset registers: data with no run, empty run, run while copying, wrap by skip
        pending_items.push_back(data_item(16'hFFFF));
        pending_items.push_back(run_item(0, 0));
        pending_items.push_back(run_item(3, 5));
        pending_items.push_back(data_item(16'h0000));
        pending_items.push_back(run_item(255, 255));
        pending_items.push_back(data_item(16'hFFFF));
        pending_items.push_back(data_item(16'hA5A5));
        pending_items.push_back(run_item(0, 255));
        pending_items.push_back(run_item(1, 0));
        pending_items.push_back(data_item(16'h5A5A));

        // narrow screen: a run of two copies, then a skip that wraps past the last line
        set_regs(2, 3);
        pending_items.push_back(run_item(2, 0));
        pending_items.push_back(data_item(16'h0001));
        pending_items.push_back(data_item(16'h0002));
        pending_items.push_back(run_item(0, 1));

        // widest registers
        set_regs(255, 255);
        pending_items.push_back(data_item(16'h8000));
        pending_items.push_back(run_item(0, 255));
        pending_items.push_back(run_item(0, 255));

        // a rejected skip across two column boundaries, and a last copy whose skip wraps
        set_regs(10, 5);
        pending_items.push_back(run_item(0, 9));
        pending_items.push_back(run_item(0, 8));
        pending_items.push_back(run_item(1, 7));
        pending_items.push_back(data_item(16'h7FFF));
        pending_items.push_back(run_item(3, 9));
        pending_items.push_back(data_item(16'h1234));

        // zero registers
        set_regs(0, 0);
        pending_items.push_back(data_item(16'h4321));
        set_regs(255, 0);
        pending_items.push_back(data_item(16'hBEEF));

        // random phases over several register settings
        set_regs(80, 200);
        push_random(200, 200);
        set_regs(255, 255);
        calm = 1'b1;
        push_random(200, 255);
        wait_idle();
        calm = 1'b0;
        set_regs(255, 3);
        push_random(60, 3);
        lw = $urandom_range(200, 255);
        sl = $urandom_range(50, 255);
        set_regs(lw, sl);
        push_random(200, sl);
        set_regs(255, 1);
        push_random(40, 1);

        // column saturation at the top, then the stuck column rejects data
        set_regs(255, 1);
        repeat (270) pending_items.push_back(run_item(0, 1));
        pending_items.push_back(data_item(16'hCAFE));
        pending_items.push_back(run_item(1, 0));
        pending_items.push_back(data_item(16'hF00D));
        push_random(10, 1);

        wait_idle();
        repeat (8) @(negedge i_clk);
        if (mismatches == 0 && expected_writes.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== column_run_skip_decompressor_top.f =====
+incdir+rtl/core
rtl/core/crsd_pkg.sv
rtl/core/crsd_cfg_regs.sv
rtl/core/crsd_in_stage.sv
rtl/core/crsd_core.sv
rtl/core/column_run_skip_decompressor_top.sv
tb/column_run_skip_decompressor_top_tb.sv
